// ===== rtl/srts_pkg.sv =====
`timescale 1ns / 1ps
// Package for the subtractive generator table seeding core.
// Holds widths, constants, the sequencer state and the control structs; no dependencies.
package srts_pkg;

  localparam int SEED_W  = 31;
  localparam int WORD_W  = 30;
  localparam int IDX_W   = 6;

  localparam logic [SEED_W-1:0] SEED_MOD = 31'd161803398;
  localparam logic [SEED_W-1:0] WORD_MOD = 31'd1000000000;

  localparam logic [IDX_W-1:0] TABLE_LAST = 6'd55;
  localparam logic [IDX_W-1:0] STEP_LAST  = 6'd54;
  localparam logic [IDX_W-1:0] SCATTER    = 6'd21;
  localparam logic [IDX_W-1:0] LAG_SPLIT  = 6'd24;
  localparam logic [IDX_W-1:0] LAG_UP     = 6'd30;
  localparam logic [IDX_W-1:0] LAG_DOWN   = 6'd25;
  localparam logic [1:0]       PASS_LAST  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_INIT,
    ST_FILL,
    ST_MIX,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_WRAP,
    OP_COND
  } alu_op_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] index;
    logic             last;
  } emit_t;

endpackage

// ===== rtl/subtractive_rng_table_seeding_core.sv =====
`timescale 1ns / 1ps
// Top level of the subtractive generator table seeding core.
// Depends on srts_pkg, srts_seq, srts_table and srts_alu.
//
// Usage:
//   Input channel (in_valid/in_ready, seed): one beat carries one seed.
//   Output channel (out_valid/out_ready, table_index, table_word, last_word):
//   each seed yields 55 beats, indexes 1 to 55 in order, last_word set on 55.
//   in_ready is high only while the sequencer is idle; one seed at a time.
//   From seed beat to first output beat: seed reduction (one conditional
//   subtract per cycle in the shared unit), setting word 55, filling the other
//   54 words, mixing (four passes of 54 read-subtract-write steps through the
//   dual-read table, plus one drain), then fetching word 1. Output runs at one
//   beat per cycle while the receiver is ready.
//   When the receiver stalls, the output register holds its beat and the
//   table read-out waits; no word is dropped.
//   Reset (rst, synchronous) returns the sequencer to idle and empties the
//   output register; table contents are not cleared.
module subtractive_rng_table_seeding_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srts_pkg::SEED_W-1:0]   seed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srts_pkg::IDX_W-1:0]    table_index,
  output logic [srts_pkg::WORD_W-1:0]   table_word,
  output logic                          last_word
);
  import srts_pkg::*;

  mem_req_t          mem_req;
  emit_t             emit;
  logic [WORD_W-1:0] wdata, rdata_a, rdata_b;
  logic              out_free;

  assign out_free = ~out_valid | out_ready;

  srts_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid & in_ready),
    .seed     (seed),
    .out_free (out_free),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .idle     (in_ready),
    .mem_req  (mem_req),
    .wdata    (wdata),
    .emit     (emit)
  );

  srts_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .wdata   (wdata),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      table_index <= emit.index;
      table_word  <= rdata_a;
      last_word   <= emit.last;
    end
  end

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (table_index == TABLE_LAST)))
    else $error("last_word does not match index 55");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, table_word} < WORD_MOD))
    else $error("table word not below one billion");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && table_index == $past(table_index) + 6'd1))
    else $error("output index did not advance by one");

  a_busy_after_seed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a seed while busy");

endmodule

// ===== rtl/srts_alu.sv =====
`timescale 1ns / 1ps
// Shared subtract unit: wrapped difference modulo one billion, or conditional subtract.
// Depends on srts_pkg.
module srts_alu (
  input  srts_pkg::alu_op_t              op,
  input  logic [srts_pkg::SEED_W-1:0]    a,
  input  logic [srts_pkg::SEED_W-1:0]    b,
  output logic [srts_pkg::SEED_W-1:0]    res,
  output logic                           ge
);
  import srts_pkg::*;

  logic [SEED_W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[SEED_W];

  always_comb begin
    case (op)
      OP_WRAP: res = ge ? diff[SEED_W-1:0] : diff[SEED_W-1:0] + WORD_MOD;
      OP_COND: res = ge ? diff[SEED_W-1:0] : a;
      default: res = a;
    endcase
  end

endmodule

// ===== rtl/srts_table.sv =====
`timescale 1ns / 1ps
// 55-word state table: one write port, two read ports with registered data.
// Depends on srts_pkg.
module srts_table (
  input  logic                          clk,
  input  srts_pkg::mem_req_t            req,
  input  logic [srts_pkg::WORD_W-1:0]   wdata,
  output logic [srts_pkg::WORD_W-1:0]   rdata_a,
  output logic [srts_pkg::WORD_W-1:0]   rdata_b
);
  import srts_pkg::*;

  logic [WORD_W-1:0] mem [55];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
    if (req.re) begin
      rdata_a <= mem[req.raddr_a];
      rdata_b <= mem[req.raddr_b];
    end
  end

endmodule

// ===== rtl/srts_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: seed reduction, scattered fill, four mixing passes and read-out.
// Depends on srts_pkg and srts_alu; drives the table port of srts_table.
module srts_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srts_pkg::SEED_W-1:0]   seed,
  input  logic                          out_free,
  input  logic [srts_pkg::WORD_W-1:0]   rdata_a,
  input  logic [srts_pkg::WORD_W-1:0]   rdata_b,
  output logic                          idle,
  output srts_pkg::mem_req_t            mem_req,
  output logic [srts_pkg::WORD_W-1:0]   wdata,
  output srts_pkg::emit_t               emit
);
  import srts_pkg::*;

  state_t            state, state_next;
  logic [SEED_W-1:0] seed_reg;
  logic [WORD_W-1:0] prev_value, carry_value;
  logic [IDX_W-1:0]  pos, pos_next;
  logic [IDX_W-1:0]  step;
  logic [1:0]        pass;
  logic              wr_pend;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W:0]    pos_sum;
  logic [IDX_W-1:0]  other_addr;

  alu_op_t           alu_op;
  logic [SEED_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_ge;

  srts_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign pos_sum    = {1'b0, pos} + {1'b0, SCATTER};
  assign pos_next   = (pos_sum >= {1'b0, TABLE_LAST}) ? IDX_W'(pos_sum - {1'b0, TABLE_LAST})
                                                      : pos_sum[IDX_W-1:0];
  assign other_addr = (step <= LAG_SPLIT) ? step + LAG_UP : step - LAG_DOWN;
  assign idle       = (state == ST_IDLE);

  always_comb begin
    alu_op = OP_WRAP;
    alu_a  = {1'b0, rdata_a};
    alu_b  = {1'b0, rdata_b};
    case (state)
      ST_REDUCE: begin
        alu_op = OP_COND;
        alu_a  = seed_reg;
        alu_b  = SEED_MOD;
      end
      ST_INIT: begin
        alu_a = SEED_MOD;
        alu_b = seed_reg;
      end
      ST_FILL: begin
        alu_a = {1'b0, prev_value};
        alu_b = {1'b0, carry_value};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_REDUCE;
      ST_REDUCE: if (!alu_ge) state_next = ST_INIT;
      ST_INIT:   state_next = ST_FILL;
      ST_FILL:   if (step == STEP_LAST) state_next = ST_MIX;
      ST_MIX:    if (step == STEP_LAST && pass == PASS_LAST) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_EMIT;
      ST_EMIT:   if (out_free && step == TABLE_LAST) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req    = '0;
    wdata      = alu_res[WORD_W-1:0];
    emit.load  = 1'b0;
    emit.index = step;
    emit.last  = (step == TABLE_LAST);
    case (state)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = STEP_LAST;
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos - 6'd1;
        wdata         = carry_value;
      end
      ST_MIX: begin
        mem_req.we      = wr_pend;
        mem_req.waddr   = wr_addr;
        mem_req.re      = 1'b1;
        mem_req.raddr_a = step - 6'd1;
        mem_req.raddr_b = other_addr;
      end
      ST_DRAIN: begin
        mem_req.we    = wr_pend;
        mem_req.waddr = wr_addr;
        mem_req.re    = 1'b1;
      end
      ST_EMIT: begin
        emit.load       = out_free;
        mem_req.re      = out_free && (step != TABLE_LAST);
        mem_req.raddr_a = step;
        mem_req.raddr_b = step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_value  <= '0;
      carry_value <= '0;
      wr_pend     <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == ST_MIX);
      case (state)
        ST_INIT: begin
          prev_value  <= alu_res[WORD_W-1:0];
          carry_value <= 30'd1;
        end
        ST_FILL: begin
          carry_value <= alu_res[WORD_W-1:0];
          prev_value  <= carry_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) seed_reg <= seed;
      end
      ST_REDUCE: begin
        if (alu_ge) seed_reg <= alu_res;
      end
      ST_INIT: begin
        pos  <= SCATTER;
        step <= 6'd1;
      end
      ST_FILL: begin
        pos <= pos_next;
        if (step == STEP_LAST) begin
          step <= 6'd1;
          pass <= 2'd0;
        end else begin
          step <= step + 6'd1;
        end
      end
      ST_MIX: begin
        wr_addr <= step - 6'd1;
        if (step == STEP_LAST) begin
          step <= 6'd1;
          pass <= pass + 2'd1;
        end else begin
          step <= step + 6'd1;
        end
      end
      ST_DRAIN: begin
        step <= 6'd1;
      end
      ST_EMIT: begin
        if (out_free && step != TABLE_LAST) step <= step + 6'd1;
      end
      default: ;
    endcase
  end

endmodule
